FILE: sv/leg_inverse_kinematics_3dof_macros.svh
// Assertion macros shared by the leg inverse kinematics RTL.
`ifndef LEG_INVERSE_KINEMATICS_3DOF_MACROS_SVH
`define LEG_INVERSE_KINEMATICS_3DOF_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LIK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("leg inverse kinematics assertion failed");

`define LIK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("leg inverse kinematics assertion failed");

`else

`define LIK_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define LIK_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: sv/lik_pkg.sv
// Shared constants, types and functions of the leg inverse kinematics block.
`timescale 1ns / 1ps
`default_nettype none

package lik_pkg;

   localparam int COORD_W = 18;
   localparam int LEN_W   = 16;
   localparam int SQ_W    = 36;
   localparam int D2_W    = 37;
   localparam int D_W     = 19;
   localparam int NUM_W   = 39;
   localparam int DEN_W   = 36;
   localparam int C_FRAC  = 24;
   localparam int C_W     = 25;
   localparam int V_W     = 49;
   localparam int S_W     = 25;
   localparam int OP_W    = 27;
   localparam int ANG_W   = 23;
   localparam int Q_W     = 27;

   localparam int ANGLE_ITERATIONS_DEF = 16;

   localparam logic [LEN_W-1:0] FEMUR_RESET = 16'd5898;
   localparam logic [LEN_W-1:0] TIBIA_RESET = 16'd9175;

   localparam logic [ANG_W-1:0] DEG90  = 23'd5898240;
   localparam logic [Q_W-1:0]   DEG90Q = 27'd5898240;
   localparam logic [Q_W-1:0]   DEG180Q = 27'd11796480;

   typedef enum logic {
      REG_FEMUR = 1'b0,
      REG_TIBIA = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [COORD_W-1:0] az;
      logic               sx;
      logic               sy;
      logic               sz;
   } coord_type;

   typedef struct packed {
      logic neg_k;
      logic neg_a;
      logic hz;
      logic unreach;
   } flags_type;

   typedef struct packed {
      coord_type        c;
      logic [D2_W-1:0]  d2;
   } side_d_type;

   typedef struct packed {
      coord_type       c;
      logic [D_W-1:0]  d;
   } side_p_type;

   typedef struct packed {
      coord_type       c;
      logic [D_W-1:0]  d;
      flags_type       fl;
   } side_q_type;

   typedef struct packed {
      coord_type       c;
      logic [D_W-1:0]  d;
      flags_type       fl;
      logic [C_W-1:0]  ck;
      logic [C_W-1:0]  ca;
   } side_s_type;

   typedef struct packed {
      logic      sx;
      logic      sy;
      logic      sz;
      flags_type fl;
   } side_o_type;

   // atan(2^-i) in degrees, Q16, rounded to nearest.
   function automatic logic [21:0] atan_q16(input int unsigned i);
      logic [21:0] v;
      case (i)
         0:  v = 22'd2949120;
         1:  v = 22'd1740967;
         2:  v = 22'd919879;
         3:  v = 22'd466945;
         4:  v = 22'd234379;
         5:  v = 22'd117304;
         6:  v = 22'd58666;
         7:  v = 22'd29335;
         8:  v = 22'd14668;
         9:  v = 22'd7334;
         10: v = 22'd3667;
         11: v = 22'd1833;
         12: v = 22'd917;
         13: v = 22'd458;
         14: v = 22'd229;
         15: v = 22'd115;
         16: v = 22'd57;
         17: v = 22'd29;
         18: v = 22'd14;
         19: v = 22'd7;
         20: v = 22'd4;
         21: v = 22'd2;
         22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   // Q16 degrees to whole degrees, clamped to [0, hi].
   function automatic logic [8:0] to_deg(input logic signed [Q_W-1:0] q,
                                         input logic [8:0] hi);
      logic [10:0] w;
      w = q[Q_W-1:16];
      if (q[Q_W-1]) begin
         return 9'd0;
      end
      if (w > {2'b00, hi}) begin
         return hi;
      end
      return w[8:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/lik_delay.sv
// Enabled shift register that carries side data alongside a pipelined unit.
`timescale 1ns / 1ps
`default_nettype none

module lik_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] data_ff [DEPTH];
   logic [W-1:0] data_in [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_tap
      if (k == 0) begin : g_first
         assign data_in[k] = din;
      end else begin : g_next
         assign data_in[k] = data_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            data_ff[k] <= data_in[k];
         end
      end
   end

   assign dout = data_ff[DEPTH-1];

endmodule

`default_nettype wire

FILE: sv/lik_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lik_isqrt #(
   parameter  int IN_W  = lik_pkg::D2_W,
   localparam int OUT_W = (IN_W + 1) / 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [IN_W-1:0]  radicand,
   output logic [OUT_W-1:0] root
);

   localparam int PAD = 2 * OUT_W;
   localparam int RW  = OUT_W + 2;

   logic [PAD-1:0]   rad_ff  [OUT_W];
   logic [PAD-1:0]   rad_in  [OUT_W];
   logic [RW-1:0]    rem_ff  [OUT_W];
   logic [RW-1:0]    rem_in  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];
   logic [OUT_W-1:0] root_in [OUT_W];

   for (genvar k = 0; k < OUT_W; k++) begin : g_stage
      logic [PAD-1:0]   rad_p;
      logic [RW-1:0]    rem_p;
      logic [OUT_W-1:0] root_p;
      logic [RW+1:0]    rem_sh;
      logic [RW+1:0]    trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign rad_p  = PAD'(radicand);
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign rad_p  = rad_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
      end

      // Bring down the next two radicand bits and try root*4+1.
      always_comb begin
         rem_sh     = {rem_p, rad_p[PAD-1:PAD-2]};
         trial      = (RW+2)'({root_p, 2'b01});
         ge         = (rem_sh >= trial);
         rem_in[k]  = ge ? RW'(rem_sh - trial) : RW'(rem_sh);
         root_in[k] = {root_p[OUT_W-2:0], ge};
         rad_in[k]  = {rad_p[PAD-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root = root_ff[OUT_W-1];

endmodule

`default_nettype wire

FILE: sv/lik_div.sv
// Pipelined restoring divider for a cosine ratio num/den <= 1 in fixed point.
`timescale 1ns / 1ps
`default_nettype none

module lik_div #(
   parameter  int W    = lik_pkg::DEN_W,
   parameter  int FRAC = lik_pkg::C_FRAC,
   localparam int QW   = FRAC + 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [W-1:0]  num,
   input  logic [W-1:0]  den,
   output logic [QW-1:0] quot
);

   logic [W-1:0]  rem_ff [QW];
   logic [W-1:0]  rem_in [QW];
   logic [W-1:0]  den_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [QW-1:0] q_in   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [W:0]    part;
      logic [W-1:0]  den_p;
      logic [QW-1:0] q_p;
      logic          ge;

      // The first stage decides the integer bit; num never exceeds den.
      if (k == 0) begin : g_first
         assign part  = {1'b0, num};
         assign den_p = den;
         assign q_p   = '0;
      end else begin : g_next
         assign part  = {rem_ff[k-1], 1'b0};
         assign den_p = den_ff[k-1];
         assign q_p   = q_ff[k-1];
      end

      always_comb begin
         ge        = (part >= {1'b0, den_p});
         rem_in[k] = ge ? W'(part - {1'b0, den_p}) : part[W-1:0];
         q_in[k]   = {q_p[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_p;
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign quot = q_ff[QW-1];

endmodule

`default_nettype wire

FILE: sv/lik_cordic.sv
// Pipelined CORDIC vectoring unit: atan(b/a) in Q16 degrees, clamped to [0, 90].
`timescale 1ns / 1ps
`default_nettype none

module lik_cordic #(
   parameter int ITER = lik_pkg::ANGLE_ITERATIONS_DEF,
   parameter int OP_W = lik_pkg::OP_W
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [OP_W-1:0]            a,
   input  logic [OP_W-1:0]            b,
   output logic [lik_pkg::ANG_W-1:0]  angle
);

   localparam int W   = OP_W + 3;
   localparam int Z_W = 25;

   logic signed [W-1:0]   x_ff  [ITER];
   logic signed [W-1:0]   x_in  [ITER];
   logic signed [W-1:0]   y_ff  [ITER];
   logic signed [W-1:0]   y_in  [ITER];
   logic signed [Z_W-1:0] z_ff  [ITER];
   logic signed [Z_W-1:0] z_in  [ITER];
   logic                  zb_ff [ITER];
   logic                  za_ff [ITER];
   logic [lik_pkg::ANG_W-1:0] angle_ff;
   logic [lik_pkg::ANG_W-1:0] angle_in;

   for (genvar k = 0; k < ITER; k++) begin : g_stage
      logic signed [W-1:0]   x_p;
      logic signed [W-1:0]   y_p;
      logic signed [Z_W-1:0] z_p;
      logic signed [Z_W-1:0] tab;
      logic                  zb_p;
      logic                  za_p;

      if (k == 0) begin : g_first
         assign x_p  = $signed(W'(a));
         assign y_p  = $signed(W'(b));
         assign z_p  = '0;
         assign zb_p = (b == '0);
         assign za_p = (a == '0);
      end else begin : g_next
         assign x_p  = x_ff[k-1];
         assign y_p  = y_ff[k-1];
         assign z_p  = z_ff[k-1];
         assign zb_p = zb_ff[k-1];
         assign za_p = za_ff[k-1];
      end

      assign tab = $signed(Z_W'(lik_pkg::atan_q16(k)));

      // Rotate toward the x axis; the shifts round toward minus infinity.
      always_comb begin
         if (!y_p[W-1]) begin
            x_in[k] = x_p + (y_p >>> k);
            y_in[k] = y_p - (x_p >>> k);
            z_in[k] = z_p + tab;
         end else begin
            x_in[k] = x_p - (y_p >>> k);
            y_in[k] = y_p + (x_p >>> k);
            z_in[k] = z_p - tab;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]  <= x_in[k];
            y_ff[k]  <= y_in[k];
            z_ff[k]  <= z_in[k];
            zb_ff[k] <= zb_p;
            za_ff[k] <= za_p;
         end
      end
   end

   // A zero numerator gives 0 degrees, a zero denominator 90 degrees.
   always_comb begin
      if (zb_ff[ITER-1]) begin
         angle_in = '0;
      end else if (za_ff[ITER-1]) begin
         angle_in = lik_pkg::DEG90;
      end else if (z_ff[ITER-1][Z_W-1]) begin
         angle_in = '0;
      end else if (z_ff[ITER-1] > $signed(Z_W'(lik_pkg::DEG90))) begin
         angle_in = lik_pkg::DEG90;
      end else begin
         angle_in = z_ff[ITER-1][lik_pkg::ANG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

`default_nettype wire

FILE: sv/leg_inverse_kinematics_3dof.sv
// Top level of the three-joint leg inverse kinematics pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "leg_inverse_kinematics_3dof_macros.svh"

// Takes one foot target per clock and returns hip, knee and ankle angles in
// whole degrees, with a flag for targets that are degenerate or out of reach.
// The block is a single pipeline with no feedback, so a new request is taken
// in every cycle while the result side keeps up. Each request passes through
// the distance square root (19 stages), the cosine divider (25 stages), the
// sine square root (25 stages), the rotation stages and eight registers of
// glue. When the result side stalls, the whole pipeline holds. The user must
// write segment lengths through the register port only while no request is
// in flight; the block itself does not enforce this.
module leg_inverse_kinematics_3dof #(
   parameter int ANGLE_ITERATIONS = lik_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // target_x[17:0], target_y[35:18], target_z[53:36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // hip_degrees[7:0], knee_degrees[16:8], ankle_degrees[24:17]
   output logic        rsp_tuser,   // unreachable[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int D_W   = lik_pkg::D_W;
   localparam int C_W   = lik_pkg::C_W;
   localparam int S_W   = lik_pkg::S_W;
   localparam int Q_W   = lik_pkg::Q_W;
   localparam int OP_W  = lik_pkg::OP_W;
   localparam int ANG_W = lik_pkg::ANG_W;
   localparam int VLD_LEN = 8 + D_W + C_W + S_W + ANGLE_ITERATIONS;

   // ---------------- configuration registers ----------------
   logic [15:0] femur_ff, femur_in;
   logic [15:0] tibia_ff, tibia_in;
   logic [31:0] f2_ff;
   logic [31:0] t2_ff;
   logic [32:0] ft2_ff;
   logic [31:0] ft_prod;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      femur_in = femur_ff;
      tibia_in = tibia_ff;
      if (csr_write) begin
         unique case (lik_pkg::reg_index_type'(csr_paddr[2]))
            lik_pkg::REG_FEMUR: femur_in = csr_pwdata[15:0];
            lik_pkg::REG_TIBIA: tibia_in = csr_pwdata[15:0];
            default:            femur_in = femur_ff;
         endcase
      end
   end

   always_comb begin
      unique case (lik_pkg::reg_index_type'(csr_paddr[2]))
         lik_pkg::REG_FEMUR: csr_prdata = {16'd0, femur_ff};
         lik_pkg::REG_TIBIA: csr_prdata = {16'd0, tibia_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         femur_ff <= lik_pkg::FEMUR_RESET;
         tibia_ff <= lik_pkg::TIBIA_RESET;
      end else begin
         femur_ff <= femur_in;
         tibia_ff <= tibia_in;
      end
   end

   // Products of the lengths are registered from the length registers, long
   // before a request reaches the stage that uses them.
   assign ft_prod = femur_ff * tibia_ff;

   always_ff @(posedge clock) begin
      f2_ff  <= femur_ff * femur_ff;
      t2_ff  <= tibia_ff * tibia_ff;
      ft2_ff <= {ft_prod, 1'b0};
   end

   // ---------------- pipeline control ----------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pipe_en;
   logic               req_accept;
   logic [VLD_LEN-1:0] vld_ff, vld_in;

   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign req_accept = req_tvalid && pipe_en;
   assign vld_in     = {vld_ff[VLD_LEN-2:0], req_accept};
   assign rsp_valid_in = vld_ff[VLD_LEN-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- stage a: magnitudes and signs ----------------
   logic [17:0] in_x, in_y, in_z;
   lik_pkg::coord_type a_ff, a_in;

   assign in_x = req_tdata[17:0];
   assign in_y = req_tdata[35:18];
   assign in_z = req_tdata[53:36];

   always_comb begin
      a_in.sx = in_x[17];
      a_in.sy = in_y[17];
      a_in.sz = in_z[17];
      a_in.ax = in_x[17] ? 18'(~in_x + 18'd1) : in_x;
      a_in.ay = in_y[17] ? 18'(~in_y + 18'd1) : in_y;
      a_in.az = in_z[17] ? 18'(~in_z + 18'd1) : in_z;
   end

   // ---------------- stage b: squares ----------------
   lik_pkg::coord_type b_ff;
   logic [35:0] b_sqx_ff, b_sqy_ff, b_sqz_ff;
   logic [35:0] sqx, sqy, sqz;

   assign sqx = a_ff.ax * a_ff.ax;
   assign sqy = a_ff.ay * a_ff.ay;
   assign sqz = a_ff.az * a_ff.az;

   // ---------------- stage c: squared distance ----------------
   lik_pkg::side_d_type c_ff, c_in;

   assign c_in.c  = b_ff;
   assign c_in.d2 = 37'(b_sqx_ff) + 37'(b_sqy_ff) + 37'(b_sqz_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_ff     <= a_in;
         b_ff     <= a_ff;
         b_sqx_ff <= sqx;
         b_sqy_ff <= sqy;
         b_sqz_ff <= sqz;
         c_ff     <= c_in;
      end
   end

   // ---------------- distance square root ----------------
   logic [D_W-1:0]      sq_d;
   lik_pkg::side_d_type sd_side;

   lik_isqrt #(.IN_W(lik_pkg::D2_W)) u_sqrt_d (
      .clock    (clock),
      .en       (pipe_en),
      .radicand (c_ff.d2),
      .root     (sq_d)
   );

   lik_delay #(.W($bits(lik_pkg::side_d_type)), .DEPTH(D_W)) u_dly_d (
      .clock (clock),
      .en    (pipe_en),
      .din   (c_ff),
      .dout  (sd_side)
   );

   // ---------------- stage p: law of cosines terms ----------------
   lik_pkg::side_p_type       p_side_ff, p_side_in;
   logic signed [38:0]        p_nk_ff, p_nk_in;
   logic signed [38:0]        p_na_ff, p_na_in;
   logic [35:0]               p_denk_ff;
   logic [34:0]               fd_prod;

   assign fd_prod     = femur_ff * sq_d;
   assign p_side_in.c = sd_side.c;
   assign p_side_in.d = sq_d;
   assign p_nk_in = $signed(39'(f2_ff)) + $signed(39'(sd_side.d2)) - $signed(39'(t2_ff));
   assign p_na_in = $signed(39'(f2_ff)) + $signed(39'(t2_ff)) - $signed(39'(sd_side.d2));

   // ---------------- stage q: cosine clamp and divider operands ----------------
   lik_pkg::side_q_type q_side_ff, q_side_in;
   logic [35:0] q_numk_ff, q_numk_in, q_denk_ff, q_denk_in;
   logic [35:0] q_numa_ff, q_numa_in, q_dena_ff, q_dena_in;
   logic [38:0] mag_k, mag_a;
   logic        clamp_k, clamp_a, hip_zero;

   always_comb begin
      mag_k    = p_nk_ff[38] ? 39'(39'd0 - p_nk_ff) : p_nk_ff;
      mag_a    = p_na_ff[38] ? 39'(39'd0 - p_na_ff) : p_na_ff;
      clamp_k  = (p_denk_ff == '0) || (mag_k > 39'(p_denk_ff));
      clamp_a  = (ft2_ff == '0) || (mag_a > 39'(ft2_ff));
      hip_zero = (p_side_ff.c.ax == '0) && (p_side_ff.c.ay == '0);
      // An out-of-range ratio is forced to exactly one.
      q_numk_in = clamp_k ? 36'd1 : mag_k[35:0];
      q_denk_in = clamp_k ? 36'd1 : p_denk_ff;
      q_numa_in = clamp_a ? 36'd1 : mag_a[35:0];
      q_dena_in = clamp_a ? 36'd1 : 36'(ft2_ff);
      q_side_in.c          = p_side_ff.c;
      q_side_in.d          = p_side_ff.d;
      q_side_in.fl.neg_k   = p_nk_ff[38];
      q_side_in.fl.neg_a   = p_na_ff[38];
      q_side_in.fl.hz      = hip_zero;
      q_side_in.fl.unreach = clamp_k || clamp_a || hip_zero;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p_side_ff <= p_side_in;
         p_nk_ff   <= p_nk_in;
         p_na_ff   <= p_na_in;
         p_denk_ff <= {fd_prod, 1'b0};
         q_side_ff <= q_side_in;
         q_numk_ff <= q_numk_in;
         q_denk_ff <= q_denk_in;
         q_numa_ff <= q_numa_in;
         q_dena_ff <= q_dena_in;
      end
   end

   // ---------------- cosine dividers ----------------
   logic [C_W-1:0]      cos_k, cos_a;
   lik_pkg::side_q_type dv_side;

   lik_div #(.W(lik_pkg::DEN_W), .FRAC(lik_pkg::C_FRAC)) u_div_k (
      .clock (clock),
      .en    (pipe_en),
      .num   (q_numk_ff),
      .den   (q_denk_ff),
      .quot  (cos_k)
   );

   lik_div #(.W(lik_pkg::DEN_W), .FRAC(lik_pkg::C_FRAC)) u_div_a (
      .clock (clock),
      .en    (pipe_en),
      .num   (q_numa_ff),
      .den   (q_dena_ff),
      .quot  (cos_a)
   );

   lik_delay #(.W($bits(lik_pkg::side_q_type)), .DEPTH(C_W)) u_dly_q (
      .clock (clock),
      .en    (pipe_en),
      .din   (q_side_ff),
      .dout  (dv_side)
   );

   // ---------------- stages r and s: 1 - c^2 ----------------
   lik_pkg::side_s_type r_side_ff, r_side_in, s_side_ff;
   logic [49:0] r_ck2_ff, r_ca2_ff, ck2, ca2;
   logic [48:0] s_vk_ff, s_va_ff;

   assign ck2 = cos_k * cos_k;
   assign ca2 = cos_a * cos_a;

   assign r_side_in.c  = dv_side.c;
   assign r_side_in.d  = dv_side.d;
   assign r_side_in.fl = dv_side.fl;
   assign r_side_in.ck = cos_k;
   assign r_side_in.ca = cos_a;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         r_side_ff <= r_side_in;
         r_ck2_ff  <= ck2;
         r_ca2_ff  <= ca2;
         s_side_ff <= r_side_ff;
         s_vk_ff   <= 49'((50'd1 << 48) - r_ck2_ff);
         s_va_ff   <= 49'((50'd1 << 48) - r_ca2_ff);
      end
   end

   // ---------------- sine square roots ----------------
   logic [S_W-1:0]      sin_k, sin_a;
   lik_pkg::side_s_type ss_side;

   lik_isqrt #(.IN_W(lik_pkg::V_W)) u_sqrt_k (
      .clock    (clock),
      .en       (pipe_en),
      .radicand (s_vk_ff),
      .root     (sin_k)
   );

   lik_isqrt #(.IN_W(lik_pkg::V_W)) u_sqrt_a (
      .clock    (clock),
      .en       (pipe_en),
      .radicand (s_va_ff),
      .root     (sin_a)
   );

   lik_delay #(.W($bits(lik_pkg::side_s_type)), .DEPTH(S_W)) u_dly_s (
      .clock (clock),
      .en    (pipe_en),
      .din   (s_side_ff),
      .dout  (ss_side)
   );

   // ---------------- rotation units ----------------
   logic [ANG_W-1:0]    ang_hip, ang_tilt, ang_kacos, ang_aacos;
   lik_pkg::side_o_type co_in, co_side;

   assign co_in.sx = ss_side.c.sx;
   assign co_in.sy = ss_side.c.sy;
   assign co_in.sz = ss_side.c.sz;
   assign co_in.fl = ss_side.fl;

   lik_cordic #(.ITER(ANGLE_ITERATIONS), .OP_W(OP_W)) u_cor_hip (
      .clock (clock),
      .en    (pipe_en),
      .a     (OP_W'({ss_side.c.ay, 8'd0})),
      .b     (OP_W'({ss_side.c.ax, 8'd0})),
      .angle (ang_hip)
   );

   lik_cordic #(.ITER(ANGLE_ITERATIONS), .OP_W(OP_W)) u_cor_tilt (
      .clock (clock),
      .en    (pipe_en),
      .a     (OP_W'({ss_side.d, 8'd0})),
      .b     (OP_W'({ss_side.c.az, 8'd0})),
      .angle (ang_tilt)
   );

   lik_cordic #(.ITER(ANGLE_ITERATIONS), .OP_W(OP_W)) u_cor_knee (
      .clock (clock),
      .en    (pipe_en),
      .a     (OP_W'(ss_side.ck)),
      .b     (OP_W'(sin_k)),
      .angle (ang_kacos)
   );

   lik_cordic #(.ITER(ANGLE_ITERATIONS), .OP_W(OP_W)) u_cor_ankle (
      .clock (clock),
      .en    (pipe_en),
      .a     (OP_W'(ss_side.ca)),
      .b     (OP_W'(sin_a)),
      .angle (ang_aacos)
   );

   lik_delay #(.W($bits(lik_pkg::side_o_type)), .DEPTH(ANGLE_ITERATIONS + 1)) u_dly_o (
      .clock (clock),
      .en    (pipe_en),
      .din   (co_in),
      .dout  (co_side)
   );

   // ---------------- output register ----------------
   logic signed [Q_W-1:0] hip_q, knee_q, kacos_q, ankle_q, tilt_q;
   logic [7:0] rsp_hip_ff;
   logic [8:0] rsp_knee_ff;
   logic [7:0] rsp_ankle_ff;
   logic       rsp_unreach_ff;
   logic [8:0] hip_deg, knee_deg, ankle_deg;
   logic       rsp_in_range;

   always_comb begin
      tilt_q = $signed(Q_W'(ang_tilt));
      if (co_side.fl.hz) begin
         hip_q = $signed(lik_pkg::DEG90Q);
      end else if (co_side.sx != co_side.sy) begin
         hip_q = $signed(lik_pkg::DEG90Q) - $signed(Q_W'(ang_hip));
      end else begin
         hip_q = $signed(lik_pkg::DEG90Q) + $signed(Q_W'(ang_hip));
      end
      kacos_q = co_side.fl.neg_k ? $signed(lik_pkg::DEG180Q) - $signed(Q_W'(ang_kacos))
                                 : $signed(Q_W'(ang_kacos));
      knee_q  = co_side.sz ? kacos_q - tilt_q + $signed(lik_pkg::DEG90Q)
                           : kacos_q + tilt_q + $signed(lik_pkg::DEG90Q);
      ankle_q = co_side.fl.neg_a ? $signed(lik_pkg::DEG180Q) - $signed(Q_W'(ang_aacos))
                                 : $signed(Q_W'(ang_aacos));
      hip_deg   = lik_pkg::to_deg(hip_q, 9'd180);
      knee_deg  = lik_pkg::to_deg(knee_q, 9'd360);
      ankle_deg = lik_pkg::to_deg(ankle_q, 9'd180);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_hip_ff     <= hip_deg[7:0];
         rsp_knee_ff    <= knee_deg;
         rsp_ankle_ff   <= ankle_deg[7:0];
         rsp_unreach_ff <= co_side.fl.unreach;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ankle_ff, rsp_knee_ff, rsp_hip_ff};
   assign rsp_tuser  = rsp_unreach_ff;

   assign rsp_in_range = (rsp_hip_ff <= 8'd180) && (rsp_knee_ff <= 9'd360)
                         && (rsp_ankle_ff <= 8'd180);

   // ---------------- assertions ----------------
   `LIK_ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, vld_ff[0])
   `LIK_ASSERT_NEXT(a_stall_holds, clock, reset, !pipe_en, $stable(vld_ff))
   `LIK_ASSERT_IMP(a_angle_range, clock, reset, rsp_tvalid, rsp_in_range)

endmodule

`default_nettype wire

FILE: tb/leg_inverse_kinematics_3dof_checker.sv
// Checker for the leg inverse kinematics block: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none

module leg_inverse_kinematics_3dof_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,   // target_x[17:0], target_y[35:18], target_z[53:36]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // hip_degrees[7:0], knee_degrees[16:8], ankle_degrees[24:17]
   input  logic        rsp_tuser,   // unreachable[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending
);

   localparam int ROTATIONS = 16;

   typedef struct {
      logic [7:0] hip;
      logic [8:0] knee;
      logic [7:0] ankle;
      logic       unreachable;
   } joint_angles_type;

   // Arctangent of 2^-i in degrees, Q16.
   localparam longint ATAN_STEP [32] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
   localparam longint Q16_90  = 64'd90 << 16;
   localparam longint Q16_180 = 64'd180 << 16;
   localparam longint unsigned UNIT_Q24 = 64'd1 << 24;

   longint unsigned  femur = lik_pkg::FEMUR_RESET;
   longint unsigned  tibia = lik_pkg::TIBIA_RESET;
   int               fail_count = 0;
   int               pending_count = 0;
   joint_angles_type angle_queue[$];

   assign failures = fail_count;
   assign pending  = pending_count;

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, bit_w;
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= r + bit_w) begin
            v -= r + bit_w;
            r = (r >> 1) + bit_w;
         end else begin
            r >>= 1;
         end
         bit_w >>= 2;
      end
      return r;
   endfunction

   // atan(b/a) in Q16 degrees by rotation, clamped to [0, 90].
   function automatic longint rotate_angle(longint unsigned a, longint unsigned b);
      longint x, y, z, dx, dy;
      x = a;
      y = b;
      z = 0;
      if (b == 0) return 0;
      if (a == 0) return Q16_90;
      for (int i = 0; i < ROTATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_STEP[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_STEP[i];
         end
      end
      if (z < 0) z = 0;
      if (z > Q16_90) z = Q16_90;
      return z;
   endfunction

   // Arccosine of num/den in Q16 degrees; an impossible cosine saturates.
   function automatic longint law_of_cosines(longint num, longint unsigned den,
                                             inout logic unreach);
      longint unsigned mag, c, s;
      longint ang;
      mag = (num < 0) ? -num : num;
      if (den == 0 || mag > den) begin
         unreach = 1'b1;
         c = UNIT_Q24;
      end else begin
         c = (mag << 24) / den;
         if (c > UNIT_Q24) c = UNIT_Q24;
      end
      s = floor_sqrt((64'd1 << 48) - c * c);
      ang = rotate_angle(c, s);
      return (num < 0) ? Q16_180 - ang : ang;
   endfunction

   function automatic longint unsigned whole_degrees(longint q, longint hi);
      if (q < 0) q = 0;
      q >>>= 16;
      if (q > hi) q = hi;
      return q;
   endfunction

   function automatic joint_angles_type solve_leg(logic [55:0] target);
      longint x, y, z, hip, knee, ankle, a;
      longint unsigned ax, ay, az, d2, d, f2, t2;
      logic unreach;
      joint_angles_type r;
      x = longint'($signed(target[17:0]));
      y = longint'($signed(target[35:18]));
      z = longint'($signed(target[53:36]));
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      f2 = femur * femur;
      t2 = tibia * tibia;
      d2 = ax * ax + ay * ay + az * az;
      d = floor_sqrt(d2);
      unreach = 1'b0;
      if (ax == 0 && ay == 0) begin
         unreach = 1'b1;
         hip = Q16_90;
      end else begin
         a = rotate_angle(ay << 8, ax << 8);
         hip = ((x < 0) != (y < 0)) ? Q16_90 - a : Q16_90 + a;
      end
      knee = law_of_cosines(longint'(f2 + d2) - longint'(t2), 2 * femur * d, unreach);
      a = rotate_angle(d << 8, az << 8);
      knee += (z < 0) ? -a : a;
      knee += Q16_90;
      ankle = law_of_cosines(longint'(f2 + t2) - longint'(d2), 2 * femur * tibia, unreach);
      r.hip = whole_degrees(hip, 180);
      r.knee = whole_degrees(knee, 360);
      r.ankle = whole_degrees(ankle, 180);
      r.unreachable = unreach;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      joint_angles_type want;
      if (reset) begin
         angle_queue.delete();
         femur = lik_pkg::FEMUR_RESET;
         tibia = lik_pkg::TIBIA_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (lik_pkg::reg_index_type'(csr_paddr[2]) == lik_pkg::REG_FEMUR)
               femur = csr_pwdata[15:0];
            else tibia = csr_pwdata[15:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (angle_queue.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = angle_queue.pop_front();
               if (rsp_tdata[7:0] != want.hip)
                  report_mismatch("hip_degrees", rsp_tdata[7:0], want.hip);
               if (rsp_tdata[16:8] != want.knee)
                  report_mismatch("knee_degrees", rsp_tdata[16:8], want.knee);
               if (rsp_tdata[24:17] != want.ankle)
                  report_mismatch("ankle_degrees", rsp_tdata[24:17], want.ankle);
               if (rsp_tuser != want.unreachable)
                  report_mismatch("unreachable", rsp_tuser, want.unreachable);
            end
         end
         if (req_tvalid && req_tready) angle_queue.push_back(solve_leg(req_tdata));
      end
      pending_count = angle_queue.size();
   end

endmodule

`default_nettype wire

FILE: tb/tb_leg_inverse_kinematics_3dof.sv
// Testbench top for the leg inverse kinematics block: stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_leg_inverse_kinematics_3dof;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 200;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          failures, pending;
   int          sender_idle_pct, receiver_stall_pct, quiet_cycles;

   leg_inverse_kinematics_3dof i_dut (.*);

   leg_inverse_kinematics_3dof_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("leg_inverse_kinematics_3dof test failed");
         $finish;
      end
   end

   task automatic write_length(lik_pkg::reg_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_lengths(logic [15:0] femur_value, logic [15:0] tibia_value);
      drain_pipeline();
      write_length(lik_pkg::REG_FEMUR, femur_value);
      write_length(lik_pkg::REG_TIBIA, tibia_value);
   endtask

   task automatic send_target(logic [17:0] x, logic [17:0] y, logic [17:0] z);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [17:0] random_coord();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return 18'($urandom_range(0, 20000) * ($urandom_range(1) ? -1 : 1));
      if (sel < 85) return 18'($urandom_range(0, 64) * ($urandom_range(1) ? -1 : 1));
      return 18'($urandom);
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 && $urandom_range(1)) drain_pipeline();
         send_target(random_coord(), random_coord(), random_coord());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed targets at the reset lengths.
      send_target(18'd0, 18'd0, 18'd0);
      send_target(18'd0, 18'd0, 18'd9000);
      send_target(18'd0, 18'd0, -18'sd9000);
      send_target(18'd5000, 18'd0, 18'd0);
      send_target(-18'sd5000, 18'd0, 18'd0);
      send_target(18'd0, 18'd9000, -18'sd6000);
      send_target(18'd4000, 18'd8000, -18'sd6000);
      send_target(-18'sd4000, 18'd8000, 18'd6000);
      send_target(18'd4000, -18'sd8000, 18'd2000);
      send_target(18'd131071, 18'd131071, 18'd131071);
      send_target(-18'sd131072, -18'sd131072, -18'sd131072);
      send_target(18'd131071, -18'sd131072, 18'd0);
      send_target(18'd1, 18'd1, 18'd1);
      send_target(-18'sd1, 18'd0, 18'd0);
      send_target(18'd15073, 18'd0, 18'd0);
      send_target(18'd0, 18'd3277, 18'd0);
      send_target(18'd2, 18'd3, -18'sd131072);

      // Phases, each with its own lengths and handshake pressure.
      send_random(250);
      set_lengths(16'd1, 16'd65535);
      sender_idle_pct = 45;
      send_random(250);
      set_lengths(16'd65535, 16'd1);
      sender_idle_pct = 0;
      receiver_stall_pct = 45;
      send_random(250);
      set_lengths(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      sender_idle_pct = 28;
      receiver_stall_pct = 28;
      send_random(250);
      set_lengths(lik_pkg::FEMUR_RESET, lik_pkg::TIBIA_RESET);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_random(250);

      drain_pipeline();
      if (failures == 0 && pending == 0) begin
         $display("leg_inverse_kinematics_3dof test passed");
      end else begin
         $display("leg_inverse_kinematics_3dof test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
